// File: src/shahu_pkg.sv
// Shared types, constants and functions for the SHA-512/SHA-384 hash unit.
`timescale 1ns / 1ps

package shahu_pkg;

  localparam int unsigned ROUNDS = 80;
  localparam int unsigned WINDOW = 16;

  typedef enum logic [1:0] {
    CMD_ABSORB   = 2'd0,
    CMD_FINALIZE = 2'd1,
    CMD_START    = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic       absorb;
    logic       start;
    logic       fin_load;
    logic       vars_load_chain;
    logic       vars_load_fin;
    logic       round_en;
    logic       add_chain;
    logic       add_fin;
    logic       pad;
    logic       blk;
    logic       two;
    logic [6:0] rnd;
    logic [2:0] widx;
  } ctl_t;

  typedef struct packed {
    logic fill_full;
    logic fill_two;
    logic variant;
  } sts_t;

  localparam logic [7:0][63:0] IV512 = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  localparam logic [7:0][63:0] IV384 = {
    64'h47b5481dbefa4fa4, 64'hdb0c2e0d64f98fa7, 64'h8eb44a8768581511, 64'h67332667ffc00b31,
    64'h152fecd8f70e5939, 64'h9159015a3070dd17, 64'h629a292a367cd507, 64'hcbbb9d5dc1059ed8
  };

  function automatic logic [63:0] round_k(input logic [6:0] t);
    logic [63:0] k;
    case (t)
      7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

// File: src/shahu_ctrl.sv
// Sequencing state machine for absorb, compression rounds, finalize and digest output.
`timescale 1ns / 1ps

module shahu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_last,
  input  shahu_pkg::sts_t sts,
  output shahu_pkg::ctl_t ctl
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ROUND  = 5'b00010,
    ST_FINISH = 5'b00100,
    ST_RELOAD = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [6:0] rnd, rnd_next;
  logic [2:0] widx, widx_next;
  logic       tgt_fin, tgt_fin_next;
  logic       blk, blk_next;
  logic       two, two_next;
  logic       acc;
  logic       last;

  assign acc  = in_valid && in_ready;
  assign last = (widx == (sts.variant ? 3'd5 : 3'd7));

  always_comb begin
    state_next   = state;
    rnd_next     = rnd;
    widx_next    = widx;
    tgt_fin_next = tgt_fin;
    blk_next     = blk;
    two_next     = two;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    ctl          = '0;
    ctl.pad      = tgt_fin;
    ctl.blk      = blk;
    ctl.two      = two;
    ctl.rnd      = rnd;
    ctl.widx     = widx;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (acc) begin
          case (in_cmd)
            shahu_pkg::CMD_ABSORB: begin
              ctl.absorb = 1'b1;
              if (sts.fill_full) begin
                ctl.vars_load_chain = 1'b1;
                tgt_fin_next = 1'b0;
                rnd_next     = 7'd0;
                state_next   = ST_ROUND;
              end
            end
            shahu_pkg::CMD_FINALIZE: begin
              ctl.fin_load        = 1'b1;
              ctl.vars_load_chain = 1'b1;
              tgt_fin_next = 1'b1;
              blk_next     = 1'b0;
              two_next     = sts.fill_two;
              rnd_next     = 7'd0;
              state_next   = ST_ROUND;
            end
            shahu_pkg::CMD_START: begin
              ctl.start = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROUND: begin
        ctl.round_en = 1'b1;
        rnd_next     = rnd + 7'd1;
        if (rnd == 7'(shahu_pkg::ROUNDS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        ctl.add_fin   = tgt_fin;
        ctl.add_chain = !tgt_fin;
        if (tgt_fin && two && !blk) begin
          blk_next   = 1'b1;
          state_next = ST_RELOAD;
        end else if (tgt_fin) begin
          widx_next  = 3'd0;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RELOAD: begin
        ctl.vars_load_fin = 1'b1;
        rnd_next   = 7'd0;
        state_next = ST_ROUND;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (last) begin
            state_next = ST_IDLE;
          end else begin
            widx_next = widx + 3'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rnd     <= 7'd0;
      widx    <= 3'd0;
      tgt_fin <= 1'b0;
      blk     <= 1'b0;
      two     <= 1'b0;
    end else begin
      state   <= state_next;
      rnd     <= rnd_next;
      widx    <= widx_next;
      tgt_fin <= tgt_fin_next;
      blk     <= blk_next;
      two     <= two_next;
    end
  end

endmodule

// File: src/shahu_dp.sv
// Datapath: block buffer, counters, chaining values, message schedule and round logic.
`timescale 1ns / 1ps

module shahu_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic [7:0]      data_byte,
  input  shahu_pkg::ctl_t ctl,
  output shahu_pkg::sts_t sts,
  output logic [63:0]     digest_word
);

  logic [63:0] blk_mem [16];
  logic [63:0] chain   [8];
  logic [63:0] fin     [8];
  logic [63:0] vars    [8];
  logic [63:0] win     [16];
  logic [6:0]  fill;
  logic [63:0] blk_cnt;
  logic        variant;

  logic [63:0] mem_word, pad_word, src_word, w_new, w, t1, t2;
  logic [63:0] s0, s1, bs0, bs1, ch, maj, len;
  logic [6:0]  p;
  logic [7:0]  pb;

  assign mem_word = blk_mem[ctl.rnd[3:0]];
  assign len      = {blk_cnt[53:0], fill, 3'b000};

  always_comb begin
    pad_word = '0;
    p        = '0;
    pb       = '0;
    for (int j = 0; j < 8; j++) begin
      p  = {ctl.rnd[3:0], 3'(j)};
      pb = 8'h00;
      if (!ctl.blk && (p < fill)) begin
        pb = mem_word[(7 - j) * 8 +: 8];
      end else if (!ctl.blk && (p == fill)) begin
        pb = 8'h80;
      end
      pad_word[(7 - j) * 8 +: 8] = pb;
    end
    if ((ctl.blk == ctl.two) && (ctl.rnd[3:0] == 4'd15)) begin
      pad_word = len;
    end
  end

  always_comb begin
    src_word = ctl.pad ? pad_word : mem_word;
    s0  = shahu_pkg::ror64(win[1], 1) ^ shahu_pkg::ror64(win[1], 8) ^ (win[1] >> 7);
    s1  = shahu_pkg::ror64(win[14], 19) ^ shahu_pkg::ror64(win[14], 61) ^ (win[14] >> 6);
    w_new = s1 + win[9] + s0 + win[0];
    w   = (ctl.rnd < 7'(shahu_pkg::WINDOW)) ? src_word : w_new;
    bs1 = shahu_pkg::ror64(vars[4], 14) ^ shahu_pkg::ror64(vars[4], 18)
        ^ shahu_pkg::ror64(vars[4], 41);
    bs0 = shahu_pkg::ror64(vars[0], 28) ^ shahu_pkg::ror64(vars[0], 34)
        ^ shahu_pkg::ror64(vars[0], 39);
    ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1  = vars[7] + bs1 + ch + shahu_pkg::round_k(ctl.rnd) + w;
    t2  = bs0 + maj;
  end

  always_ff @(posedge clk) begin
    if (ctl.absorb) begin
      blk_mem[fill[6:3]][{~fill[2:0], 3'b000} +: 8] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w;
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end else if (ctl.vars_load_chain) begin
      vars <= chain;
    end else if (ctl.vars_load_fin) begin
      vars <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin_load) begin
      fin <= chain;
    end else if (ctl.add_fin) begin
      for (int i = 0; i < 8; i++) begin
        fin[i] <= fin[i] + vars[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= 1'b0;
      fill    <= '0;
      blk_cnt <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= shahu_pkg::IV512[i];
      end
    end else begin
      if (cfg_wr_en) begin
        variant <= cfg_wr_data;
      end
      if (ctl.start) begin
        fill    <= '0;
        blk_cnt <= '0;
        for (int i = 0; i < 8; i++) begin
          chain[i] <= variant ? shahu_pkg::IV384[i] : shahu_pkg::IV512[i];
        end
      end else if (ctl.absorb) begin
        fill <= fill + 7'd1;
        if (fill == 7'd127) begin
          blk_cnt <= blk_cnt + 64'd1;
        end
      end else if (ctl.add_chain) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + vars[i];
        end
      end
    end
  end

  assign sts.fill_full = (fill == 7'd127);
  assign sts.fill_two  = (fill > 7'd111);
  assign sts.variant   = variant;
  assign digest_word   = fin[ctl.widx];

endmodule

// File: src/sha512_sha384_hash_unit.sv
// Top level of the streaming SHA-512/SHA-384 hash unit.
`timescale 1ns / 1ps

// Each transfer carries a command in s_tuser (0 absorb byte, 1 finalize, 2 start, 3 ignored)
// and a byte in s_tdata. Start, a plain absorb and an ignored command leave the unit idle.
// The absorb that completes a 128-byte block runs 80 rounds of the shared one-round
// compression unit and then folds the result into the chaining value; no transfer is
// accepted meanwhile. Finalize pads a copy of the state and runs one or two such
// compressions (two when 112 or more bytes sit in the buffer, with a reload step between
// them), then presents 8 digest words (SHA-512) or 6 (SHA-384) one per transfer on the
// master side. The live state is kept, so absorbing may go on. cfg_wr_data, written while
// cfg_wr_en is high, selects the variant (1 = SHA-384); it is used at start for the initial
// vector and during digest output for the output length.
module sha512_sha384_hash_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [63:0] digest_word, [66:64] word_index, [71:67] zero
  output logic        m_tlast    // last_word
);

  shahu_pkg::ctl_t ctl;
  shahu_pkg::sts_t sts;
  logic [63:0]     digest_word;

  shahu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_last  (m_tlast),
    .sts       (sts),
    .ctl       (ctl)
  );

  shahu_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .data_byte   (s_tdata),
    .ctl         (ctl),
    .sts         (sts),
    .digest_word (digest_word)
  );

  assign m_tdata = {5'b00000, ctl.widx, digest_word};

endmodule

// File: verif/sha_digest_checker.sv
// Checker for the SHA-512/SHA-384 hash unit: tracks transfers, predicts digests, compares.
`timescale 1ns / 1ps

module sha_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending_words
);

  typedef struct {
    logic [63:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic [63:0] k_tab [80];
  logic [63:0] iv512_tab [8];
  logic [63:0] iv384_tab [8];

  logic        sel_384;
  logic [63:0] chain [8];
  logic [7:0]  buffer [128];
  logic [6:0]  fill;
  logic [63:0] blocks;
  digest_word_t expected_words[$];

  initial begin
    k_tab = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
    iv512_tab = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    iv384_tab = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
  end

  function automatic logic [63:0] rotr(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // Run 80 rounds of one 128-byte block into h.
  task automatic compress_block(inout logic [63:0] h [8], input logic [7:0] blk [128]);
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = '0;
      for (int j = 0; j < 8; j++) w[i] = {w[i][55:0], blk[i*8+j]};
    end
    for (int t = 16; t < 80; t++) begin
      w[t] = (rotr(w[t-2], 19) ^ rotr(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
           + (rotr(w[t-15], 1) ^ rotr(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
    end
    v = h;
    for (int t = 0; t < 80; t++) begin
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[t] + w[t];
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
  endtask

  task automatic predict_digest();
    logic [7:0]  lo [128];
    logic [7:0]  hi [128];
    logic [63:0] h [8];
    logic [63:0] bits;
    int          nwords;
    bit          two;
    bits = ((blocks << 7) + 64'(fill)) << 3;
    two = (fill > 111);
    for (int i = 0; i < 128; i++) begin
      lo[i] = (i < fill) ? buffer[i] : 8'h00;
      hi[i] = 8'h00;
    end
    lo[fill] = 8'h80;
    for (int i = 0; i < 8; i++) begin
      if (two) hi[127-i] = bits[8*i +: 8];
      else lo[127-i] = bits[8*i +: 8];
    end
    h = chain;
    compress_block(h, lo);
    if (two) compress_block(h, hi);
    nwords = sel_384 ? 6 : 8;
    for (int i = 0; i < nwords; i++)
      expected_words.push_back('{word: h[i], idx: 3'(i), last: (i == nwords - 1)});
  endtask

  assign pending_words = expected_words.size();

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst) begin
      sel_384 = 1'b0;
      chain = iv512_tab;
      fill = '0;
      blocks = '0;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) sel_384 = cfg_wr_data;
      if (s_tvalid && s_tready) begin
        case (shahu_pkg::cmd_t'(s_tuser))
          shahu_pkg::CMD_ABSORB: begin
            buffer[fill] = s_tdata;
            fill = fill + 7'd1;
            if (fill == 0) begin
              compress_block(chain, buffer);
              blocks = blocks + 64'd1;
            end
          end
          shahu_pkg::CMD_START: begin
            chain = sel_384 ? iv384_tab : iv512_tab;
            fill = '0;
            blocks = '0;
          end
          shahu_pkg::CMD_FINALIZE: predict_digest();
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                   m_tdata[63:0], m_tdata[66:64], m_tlast);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (m_tdata[63:0] !== exp_w.word || m_tdata[66:64] !== exp_w.idx ||
              m_tlast !== exp_w.last || m_tdata[71:67] !== 5'd0) begin
            $display("%0t: expected word %h idx %0d last %0b, actual %h idx %0d last %0b",
                     $time, exp_w.word, exp_w.idx, exp_w.last, m_tdata[63:0],
                     m_tdata[66:64], m_tlast);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: verif/tb_top.sv
// Testbench top for the SHA-512/SHA-384 hash unit: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  int          fail_count;
  int          pending_words;
  int          idle_cycles = 0;
  bit          stall_hold = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sha512_sha384_hash_unit dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  sha_digest_checker checker_i (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  // Receiver: stall pattern, with a long hold-off on request.
  always @(posedge clk) begin
    if (stall_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send(shahu_pkg::cmd_t cmd, logic [7:0] data);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Send with a random gap after the transfer, bursty.
  task automatic send_paced(shahu_pkg::cmd_t cmd, logic [7:0] data, ref int burst);
    send(cmd, data);
    if (burst > 0) burst--;
    else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      burst = $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_variant(logic v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int burst;
    int len;
    burst = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: finalize without start, ignored command, byte extremes
    send(shahu_pkg::CMD_FINALIZE, 8'h00);
    send(shahu_pkg::CMD_UNUSED, 8'hff);
    send(shahu_pkg::CMD_START, 8'h00);
    send(shahu_pkg::CMD_ABSORB, 8'h00);
    send(shahu_pkg::CMD_ABSORB, 8'hff);
    send(shahu_pkg::CMD_ABSORB, 8'h55);
    send(shahu_pkg::CMD_ABSORB, 8'haa);
    send(shahu_pkg::CMD_FINALIZE, 8'h00);
    send(shahu_pkg::CMD_ABSORB, 8'h01);
    send(shahu_pkg::CMD_FINALIZE, 8'hff);
    drain();
    set_variant(1'b1);
    send(shahu_pkg::CMD_START, 8'h00);
    send(shahu_pkg::CMD_ABSORB, 8'h80);
    send(shahu_pkg::CMD_FINALIZE, 8'h00);
    drain();
    // variant change mid-message: output length follows the new setting
    set_variant(1'b0);
    send(shahu_pkg::CMD_ABSORB, 8'h7f);
    send(shahu_pkg::CMD_FINALIZE, 8'h00);
    drain();

    // long receiver hold-off while digests pile up
    stall_hold = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        stall_hold = 1'b0;
      end
      begin
        repeat (4) begin
          send(shahu_pkg::CMD_FINALIZE, 8'h00);
          send(shahu_pkg::CMD_ABSORB, 8'($urandom));
        end
      end
    join
    drain();

    // random messages: one near the two-block padding boundary, then continue it past a
    // block boundary, then a medium message that usually begins with a start
    for (int phase = 0; phase < 3; phase++) begin
      set_variant(phase[0]);
      if (phase == 0) len = $urandom_range(108, 115);
      else if (phase == 1) len = $urandom_range(20, 30);
      else len = $urandom_range(40, 80);
      if (phase != 1 && $urandom_range(0, 5) != 0)
        send_paced(shahu_pkg::CMD_START, 8'($urandom), burst);
      for (int b = 0; b < len; b++) begin
        if ($urandom_range(0, 60) == 0)
          send_paced(shahu_pkg::CMD_UNUSED, 8'($urandom), burst);
        if ($urandom_range(0, 80) == 0)
          send_paced(shahu_pkg::CMD_FINALIZE, 8'($urandom), burst);
        send_paced(shahu_pkg::CMD_ABSORB, 8'($urandom), burst);
      end
      send_paced(shahu_pkg::CMD_FINALIZE, 8'($urandom), burst);
      drain();
    end

    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
src/shahu_pkg.sv
src/shahu_ctrl.sv
src/shahu_dp.sv
src/sha512_sha384_hash_unit.sv
verif/sha_digest_checker.sv
verif/tb_top.sv
